@@ hw/rtl/csal_pkg.sv @@
// Shared types and constants of the circle spot amplification lookup.
package csal_pkg;

    localparam int COORD_W = 16;
    localparam int RADIUS_W = 12;
    localparam int COEF_W = 16;
    localparam int POS_W = COORD_W + 1;
    localparam int DIFF_W = COORD_W + 2;
    localparam int SQ_W = 2 * DIFF_W - 1;
    localparam int R2_W = 2 * RADIUS_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [COEF_W-1:0] COEF_ONE = 16'd16384;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPOT_COUNT = 2'd2;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic [COEF_W-1:0]          coef;
        logic [RADIUS_W-1:0]        radius;
        logic signed [COORD_W-1:0]  cy;
        logic signed [COORD_W-1:0]  cx;
    } spot_entry_t;

    typedef struct packed {
        logic valid;
        logic last;
    } scan_tag_t;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic              contained;
        logic [COEF_W-1:0] coef;
    } test_res_t;

endpackage

@@ hw/rtl/csal_spot_mem.sv @@
// Spot table memory: one write port, one registered read port.
module csal_spot_mem
    import csal_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  spot_entry_t      wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output spot_entry_t      rd_data
);

    spot_entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/csal_spot_test.sv @@
// Three-stage containment test of one table entry against the query point.
module csal_spot_test
    import csal_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  scan_tag_t                tag_in,
    input  spot_entry_t              entry,
    input  logic signed [POS_W-1:0]  px,
    input  logic signed [POS_W-1:0]  py,
    output test_res_t                res
);

    // Stage 1: distances to the centre.
    logic signed [DIFF_W-1:0] dx_reg, dy_reg;
    logic [RADIUS_W-1:0]      r1_reg;
    logic [COEF_W-1:0]        coef1_reg;
    scan_tag_t                tag1_reg;

    // Stage 2: squares.
    logic [SQ_W-1:0]          dx2_reg, dy2_reg;
    logic [R2_W-1:0]          r2_reg;
    logic [COEF_W-1:0]        coef2_reg;
    scan_tag_t                tag2_reg;

    // Stage 3: compare.
    test_res_t                res_reg;

    logic signed [DIFF_W-1:0]   dx_next, dy_next;
    logic signed [2*DIFF_W-1:0] prod_x, prod_y;
    logic [SQ_W:0]              d2_sum;

    always_comb begin
        dx_next = {px[POS_W-1], px} - {{2{entry.cx[COORD_W-1]}}, entry.cx};
        dy_next = {py[POS_W-1], py} - {{2{entry.cy[COORD_W-1]}}, entry.cy};
        prod_x  = dx_reg * dx_reg;
        prod_y  = dy_reg * dy_reg;
        d2_sum  = {1'b0, dx2_reg} + {1'b0, dy2_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg      <= '0;
            tag2_reg      <= '0;
            res_reg.valid <= 1'b0;
            res_reg.last  <= 1'b0;
        end else begin
            tag1_reg      <= tag_in;
            tag2_reg      <= tag1_reg;
            res_reg.valid <= tag2_reg.valid;
            res_reg.last  <= tag2_reg.last;
        end
        dx_reg         <= dx_next;
        dy_reg         <= dy_next;
        r1_reg         <= entry.radius;
        coef1_reg      <= entry.coef;
        // Squares are never negative, so the sign bit of the product is dropped.
        dx2_reg        <= prod_x[SQ_W-1:0];
        dy2_reg        <= prod_y[SQ_W-1:0];
        r2_reg         <= r1_reg * r1_reg;
        coef2_reg      <= coef1_reg;
        res_reg.contained <= d2_sum < {{(SQ_W + 1 - R2_W){1'b0}}, r2_reg};
        res_reg.coef   <= coef2_reg;
    end

    assign res = res_reg;

endmodule

@@ hw/rtl/circle_spot_amplification_lookup.sv @@
// Top level of the circle spot amplification lookup: control, registers and output.
//
// Usage: the s_ channel carries load and query items, told apart by s_tuser.
// A load item writes one spot table entry in the cycle it is accepted and
// gives no result. A query item scans table entries 0 to n-1, where n is
// spot_count limited to MAX_SPOTS, and gives one result item on the m_
// channel: the coefficient of the last spot that strictly contains the
// point, or 1.0 (Q2.14) with hit low when none does.
// Throughput: a load leaves the block idle. A query reads one table entry
// per cycle through the single memory read port and a three-stage test
// pipeline; its result enters the output register as the block returns to
// idle and takes the next item. The configuration channel is always ready;
// registers must be written only while no item is in flight; the block
// does not enforce it. Reset clears the registers and control state;
// table contents stay undefined until loaded. When the receiver stalls,
// the result waits in the output register while the next item is still
// accepted; a second query waits at its end until that register empties.
module circle_spot_amplification_lookup
    import csal_pkg::*;
#(
    parameter int MAX_SPOTS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // spot_index[5:0], spot_cx[21:6], spot_cy[37:22], spot_radius[49:38],
    // spot_coef[65:50], query_x[81:66], query_y[97:82], zeros above
    input  logic [103:0]         s_tdata,
    // kind[0]
    input  logic [0:0]           s_tuser,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // amplification[15:0]
    output logic [15:0]          m_tdata,
    // hit[0]
    output logic [0:0]           m_tuser
);

    localparam int IDX_W = (MAX_SPOTS > 1) ? $clog2(MAX_SPOTS) : 1;
    localparam int CNT_W = $clog2(MAX_SPOTS + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_WAIT   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]               state_reg, state_next;
    logic signed [COORD_W-1:0] origin_x_reg, origin_y_reg;
    logic [6:0]               spot_count_reg;
    logic [IDX_W-1:0]         scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]         last_idx_reg;
    logic signed [POS_W-1:0]  px_reg, py_reg;
    logic [COEF_W-1:0]        acc_amp_reg, acc_amp_next;
    logic                     acc_hit_reg, acc_hit_next;
    scan_tag_t                rd_tag_reg, rd_tag_next;
    logic                     m_tvalid_reg;
    logic [COEF_W-1:0]        m_amp_reg;
    logic                     m_hit_reg;

    logic [5:0]                spot_index;
    logic signed [COORD_W-1:0] query_x, query_y;
    spot_entry_t               load_entry, rd_entry;
    logic                      accept, load_en, rd_en, out_load;
    logic [CNT_W-1:0]          n_eff;
    test_res_t                 res;

    assign spot_index        = s_tdata[5:0];
    assign load_entry.cx     = s_tdata[21:6];
    assign load_entry.cy     = s_tdata[37:22];
    assign load_entry.radius = s_tdata[49:38];
    assign load_entry.coef   = s_tdata[65:50];
    assign query_x           = s_tdata[81:66];
    assign query_y           = s_tdata[97:82];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign load_en   = accept && (s_tuser[0] == KIND_LOAD) && (int'(spot_index) < MAX_SPOTS);
    assign rd_en     = (state_reg == ST_SCAN);
    assign out_load  = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);

    assign n_eff = (int'(spot_count_reg) > MAX_SPOTS) ? CNT_W'(MAX_SPOTS)
                                                      : CNT_W'(spot_count_reg);

    always_comb begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        acc_amp_next  = acc_amp_reg;
        acc_hit_next  = acc_hit_reg;
        rd_tag_next   = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (s_tuser[0] == KIND_QUERY)) begin
                    scan_idx_next = '0;
                    acc_amp_next  = COEF_ONE;
                    acc_hit_next  = 1'b0;
                    state_next    = (n_eff == '0) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                rd_tag_next.valid = 1'b1;
                rd_tag_next.last  = (scan_idx_reg == last_idx_reg);
                scan_idx_next     = scan_idx_reg + 1'b1;
                if (scan_idx_reg == last_idx_reg) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (res.valid && res.last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        // Later entries override earlier ones, so the last match wins.
        if (res.valid && res.contained) begin
            acc_amp_next = res.coef;
            acc_hit_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            spot_count_reg <= '0;
            rd_tag_reg     <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_tag_reg <= rd_tag_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_ORIGIN_X:   origin_x_reg   <= cfg_data;
                    CFG_ORIGIN_Y:   origin_y_reg   <= cfg_data;
                    CFG_SPOT_COUNT: spot_count_reg <= cfg_data[6:0];
                    default: begin
                    end
                endcase
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        scan_idx_reg <= scan_idx_next;
        acc_amp_reg  <= acc_amp_next;
        acc_hit_reg  <= acc_hit_next;
        if (accept) begin
            px_reg       <= {query_x[COORD_W-1], query_x} - {origin_x_reg[COORD_W-1], origin_x_reg};
            py_reg       <= {query_y[COORD_W-1], query_y} - {origin_y_reg[COORD_W-1], origin_y_reg};
            last_idx_reg <= IDX_W'(n_eff - 1'b1);
        end
        if (out_load) begin
            m_amp_reg <= acc_amp_reg;
            m_hit_reg <= acc_hit_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_amp_reg;
    assign m_tuser[0] = m_hit_reg;

    csal_spot_mem #(
        .DEPTH (MAX_SPOTS),
        .IDX_W (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (load_en),
        .wr_addr (IDX_W'(spot_index)),
        .wr_data (load_entry),
        .rd_en   (rd_en),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_entry)
    );

    csal_spot_test u_test (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tag_in  (rd_tag_reg),
        .entry   (rd_entry),
        .px      (px_reg),
        .py      (py_reg),
        .res     (res)
    );

endmodule

@@ dv/circle_spot_amplification_lookup_tb.sv @@
// Testbench for the circle spot amplification lookup: scoreboard, drivers and stimulus.
module circle_spot_amplification_lookup_tb;
    import csal_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int PHASES = 13;
    localparam int ITEMS_PER_PHASE = 98;
    localparam int SETTLE_CYCLES = 10;
    localparam int DRAIN_CYCLES = 80;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int STALL_LIMIT = 4000;
    localparam int PRINT_LIMIT = 200;
    localparam logic [15:0] COORD_MIN = 16'h8000;
    localparam logic [15:0] COORD_MAX = 16'h7FFF;

    typedef enum {
        FLOW_FREE,
        FLOW_TX_GAPS,
        FLOW_RX_STALLS,
        FLOW_BOTH
    } flow_mode_e;

    typedef struct packed {
        logic [COEF_W-1:0] amp;
        logic              hit;
    } amp_result_t;

    // Holds its own copy of the spot table and registers, and the queue of
    // results that accepted queries still owe.
    class spot_scoreboard;
        spot_entry_t        spots [TABLE_DEPTH];
        logic signed [15:0] org_x;
        logic signed [15:0] org_y;
        logic [6:0]         spot_count;
        amp_result_t        expected_q [$];
        int                 mismatches;
        int                 loads;
        int                 queries;
        int                 hits;
        int                 reg_writes;

        function new();
            org_x = '0;
            org_y = '0;
            spot_count = '0;
            mismatches = 0;
            loads = 0;
            queries = 0;
            hits = 0;
            reg_writes = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
            reg_writes++;
            case (idx)
                CFG_ORIGIN_X: org_x = value;
                CFG_ORIGIN_Y: org_y = value;
                CFG_SPOT_COUNT: spot_count = value[6:0];
                default: ;
            endcase
        endfunction

        // Differences are formed at full width so that nothing wraps.
        function amp_result_t lookup(logic [15:0] qx, logic [15:0] qy);
            amp_result_t             res;
            logic [POS_W-1:0]        px;
            logic [POS_W-1:0]        py;
            logic signed [DIFF_W-1:0] dx;
            logic signed [DIFF_W-1:0] dy;
            longint                  d2;
            longint                  r2;
            int                      n;
            res.amp = COEF_ONE;
            res.hit = 1'b0;
            px = {qx[15], qx} - {org_x[15], org_x};
            py = {qy[15], qy} - {org_y[15], org_y};
            n = (spot_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(spot_count);
            for (int i = 0; i < n; i++) begin
                dx = {px[POS_W-1], px} - {spots[i].cx[15], spots[i].cx[15], spots[i].cx};
                dy = {py[POS_W-1], py} - {spots[i].cy[15], spots[i].cy[15], spots[i].cy};
                d2 = longint'(dx) * longint'(dx) + longint'(dy) * longint'(dy);
                r2 = longint'(spots[i].radius) * longint'(spots[i].radius);
                if (d2 < r2) begin
                    res.amp = spots[i].coef;
                    res.hit = 1'b1;
                end
            end
            return res;
        endfunction

        function void note_item(logic [0:0] kind, logic [103:0] data);
            spot_entry_t e;
            amp_result_t res;
            if (kind == KIND_LOAD) begin
                e.cx = data[21:6];
                e.cy = data[37:22];
                e.radius = data[49:38];
                e.coef = data[65:50];
                spots[data[5:0]] = e;
                loads++;
            end else begin
                res = lookup(data[81:66], data[97:82]);
                expected_q.push_back(res);
                queries++;
                if (res.hit) hits++;
            end
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= PRINT_LIMIT) $display("mismatch at %0t: %s", $time, what);
        endtask

        task check_result(logic [15:0] amp, logic hit);
            amp_result_t want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result with none pending, amp %0d hit %0d",
                                          amp, hit));
                return;
            end
            want = expected_q.pop_front();
            if (amp !== want.amp)
                report_mismatch($sformatf("amplification %0d, predicted %0d", amp, want.amp));
            if (hit !== want.hit)
                report_mismatch($sformatf("hit %0d, predicted %0d", hit, want.hit));
        endtask

        task close_out();
            if (expected_q.size() != 0)
                report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
        endtask
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [103:0]         s_tdata = '0;
    logic [0:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [15:0]          m_tdata;
    logic [0:0]           m_tuser;

    spot_scoreboard sb;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_off_left = 0;
    int quiet_cycles = 0;

    circle_spot_amplification_lookup #(
        .MAX_SPOTS(TABLE_DEPTH)
    ) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    // The receiver stalls at random, or holds off entirely while a hold-off
    // count is pending.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_off_left > 0) begin
            m_tready <= 1'b0;
            hold_off_left--;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready) sb.note_item(s_tuser, s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0]);
        end
    end

    always @(posedge aclk) begin
        if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_flow(input flow_mode_e mode);
        case (mode)
            FLOW_FREE: begin tx_idle_pct = 0; rx_stall_pct = 0; end
            FLOW_TX_GAPS: begin tx_idle_pct = 52; rx_stall_pct = 0; end
            FLOW_RX_STALLS: begin tx_idle_pct = 0; rx_stall_pct = 52; end
            default: begin tx_idle_pct = 6; rx_stall_pct = 6; end
        endcase
    endtask

    task automatic offer(input logic [0:0] kind, input logic [103:0] data);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= data;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Fields not used by an item's kind carry random bits.
    function automatic logic [103:0] pack_item(logic [5:0] idx, logic [15:0] cx,
                                               logic [15:0] cy, logic [11:0] radius,
                                               logic [15:0] coef, logic [15:0] qx,
                                               logic [15:0] qy);
        logic [103:0] data;
        data = '0;
        data[5:0] = idx;
        data[21:6] = cx;
        data[37:22] = cy;
        data[49:38] = radius;
        data[65:50] = coef;
        data[81:66] = qx;
        data[97:82] = qy;
        return data;
    endfunction

    task automatic send_load(input logic [5:0] idx, input logic [15:0] cx,
                             input logic [15:0] cy, input logic [11:0] radius,
                             input logic [15:0] coef);
        offer(KIND_LOAD, pack_item(idx, cx, cy, radius, coef,
                                   16'($urandom), 16'($urandom)));
    endtask

    task automatic send_query(input logic [15:0] qx, input logic [15:0] qy);
        offer(KIND_QUERY, pack_item(6'($urandom), 16'($urandom), 16'($urandom),
                                    12'($urandom), 16'($urandom), qx, qy));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.expected_q.size() != 0);
    endtask

    // Loads give no result, so a short settle follows the last result.
    task automatic wait_idle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_registers(input logic [15:0] ox, input logic [15:0] oy,
                                 input logic [6:0] count);
        logic [CFG_IDX_W-1:0] idx [3];
        logic [15:0]          val [3];
        idx = '{CFG_ORIGIN_X, CFG_ORIGIN_Y, CFG_SPOT_COUNT};
        val = '{ox, oy, {9'd0, count}};
        for (int w = 0; w < 3; w++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[w];
            cfg_data <= val[w];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_origin(int phase);
        if (phase == 3) return COORD_MIN;
        if (phase == 7) return COORD_MAX;
        if (phase % 3 == 0) return 16'($urandom);
        return 16'($urandom_range(0, 16000) - 8000);
    endfunction

    initial begin
        int          counts [PHASES] = '{64, 127, 3, 1, 0, 64, 65, 16, 40, 2, 100, 8, 24};
        int          n;
        int          pick;
        int          r;
        int          ox;
        int          oy;
        spot_entry_t e;
        logic [5:0]  idx;
        logic [15:0] qx;
        logic [15:0] qy;

        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. With the count at zero nothing can match.
        set_flow(FLOW_FREE);
        send_query(COORD_MIN, COORD_MIN);
        send_query(COORD_MAX, COORD_MAX);
        send_load(6'd0, 16'd0, 16'd0, 12'd100, 16'h0000);
        send_load(6'd1, 16'd50, 16'd0, 12'd100, 16'hFFFF);
        send_load(6'd2, COORD_MIN, COORD_MAX, 12'hFFF, 16'd12345);
        send_load(6'd3, COORD_MAX, COORD_MIN, 12'd0, 16'd1);
        send_query(16'd0, 16'd0);
        wait_idle();
        set_registers(16'd0, 16'd0, 7'd4);
        // Overlapping spots: the later entry wins.
        send_query(16'd0, 16'd0);
        // Exactly on the circle is outside; one step in is inside.
        send_query(-16'sd100, 16'd0);
        send_query(-16'sd99, 16'd0);
        // A zero radius never matches, even at the centre.
        send_query(COORD_MAX, COORD_MIN);
        send_query(COORD_MIN, COORD_MAX);
        send_query(COORD_MIN + 16'd4094, COORD_MAX);
        send_query(COORD_MIN + 16'd4095, COORD_MAX);
        wait_idle();
        // Origin at the far corner: a 16-bit wrap would land next to entry 0.
        set_registers(COORD_MAX, COORD_MIN, 7'd4);
        send_query(COORD_MIN, COORD_MAX);
        send_query(COORD_MAX, COORD_MIN);
        wait_idle();
        set_registers(COORD_MIN, COORD_MAX, 7'd2);
        send_query(COORD_MAX, COORD_MIN);
        send_query(COORD_MIN + 16'd50, COORD_MAX);
        wait_idle();

        // Random part: every entry is loaded at the start of the first phase,
        // before any query can read it.
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            set_flow(flow_mode_e'(p % 4));
            set_registers(pick_origin(p), pick_origin(p), 7'(counts[p]));
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (p == 2 && k == 10) hold_off_left = HOLD_OFF_CYCLES;
                if (p % 2 == 1 && k == 50) wait_drained();
                if ((p == 0 && k < TABLE_DEPTH) || $urandom_range(0, 99) < 30) begin
                    idx = (p == 0 && k < TABLE_DEPTH) ? 6'(k) : 6'($urandom);
                    if ($urandom_range(0, 99) < 70) begin
                        e.cx = 16'($urandom_range(0, 3000) - 1500);
                        e.cy = 16'($urandom_range(0, 3000) - 1500);
                    end else begin
                        e.cx = 16'($urandom);
                        e.cy = 16'($urandom);
                    end
                    pick = $urandom_range(0, 9);
                    if (pick < 5) e.radius = 12'($urandom_range(0, 600));
                    else if (pick < 9) e.radius = 12'($urandom);
                    else e.radius = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
                    pick = $urandom_range(0, 9);
                    if (pick == 0) e.coef = COEF_ONE;
                    else if (pick == 1) e.coef = 16'hFFFF;
                    else if (pick == 2) e.coef = 16'h0000;
                    else e.coef = 16'($urandom);
                    send_load(idx, e.cx, e.cy, e.radius, e.coef);
                end else begin
                    n = (sb.spot_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(sb.spot_count);
                    if (n > 0 && $urandom_range(0, 99) < 65) begin
                        // Aim at or around one of the spots in use.
                        e = sb.spots[$urandom_range(0, n - 1)];
                        r = int'(e.radius);
                        if ($urandom_range(0, 9) == 0) begin
                            pick = $urandom_range(0, 3);
                            ox = (pick == 0) ? r : (pick == 1) ? -r : 0;
                            oy = (pick == 2) ? r : (pick == 3) ? -r : 0;
                        end else begin
                            ox = int'($urandom_range(0, 2 * r + 4)) - (r + 2);
                            oy = int'($urandom_range(0, 2 * r + 4)) - (r + 2);
                        end
                        qx = 16'(int'(sb.org_x) + int'(e.cx) + ox);
                        qy = 16'(int'(sb.org_y) + int'(e.cy) + oy);
                    end else begin
                        qx = 16'($urandom);
                        qy = 16'($urandom);
                    end
                    send_query(qx, qy);
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        sb.close_out();
        $display("Covered %0d spot loads and %0d queries, %0d of them inside a spot,",
                 sb.loads, sb.queries, sb.hits);
        $display("over %0d register writes with gaps, stalls and a long receiver hold-off.",
                 sb.reg_writes);
        if (sb.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ circle_spot_amplification_lookup.f @@
hw/rtl/csal_pkg.sv
hw/rtl/csal_spot_mem.sv
hw/rtl/csal_spot_test.sv
hw/rtl/circle_spot_amplification_lookup.sv
dv/circle_spot_amplification_lookup_tb.sv
